>>> rtl/cirrl_pkg.sv
// Shared types and constants for the closed ID reuse rate limit table.
// No dependencies; used by cirrl_cell and the top level.
package cirrl_pkg;

	localparam int TableDepth = 16;
	localparam int CntW = $clog2(TableDepth + 1);
	localparam logic [63:0] RateLimitReset = 64'd1000000000;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_DEL = 3'd1;
	localparam logic [2:0] OP_FIND = 3'd2;
	localparam logic [2:0] OP_CHECK = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_RATE_LIMITED = 3'd3;
	localparam logic [2:0] ST_REUSABLE = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic [63:0] corr_id;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [63:0] now_ns;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] status;
		logic [63:0] result_id;
		logic [4:0] entry_count;
	} out_beat_t;

	typedef struct packed {
		logic [63:0] id;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [63:0] closed;
	} entry_t;

	// command from the controller to every cell
	typedef struct packed {
		logic shift_in;    // take neighbor entry (below)
		logic shift_out;   // take neighbor entry (above)
		logic load_new;    // load the new entry (cell 0 only)
		logic refresh;     // refresh closed time
	} cell_cmd_t;

	// match flags from a cell
	typedef struct packed {
		logic id_hit;
		logic addr_young;
		logic old;
	} cell_flag_t;

endpackage

>>> rtl/closed_id_reuse_rate_limit_table.sv
// Top level: controller over a row of cirrl_cell slots, output register.
// Uses cirrl_pkg and cirrl_cell.
//
// channel | dir | handshake      | payload
// in      | in  | in_valid/stall | in_beat (cirrl_pkg::in_beat_t)
// out     | out | out_valid/stall| out_beat (cirrl_pkg::out_beat_t)
// cfg     | in  | cfg_we         | cfg_data (rate limit, 64 bits)
//
// Each item takes 2 cycles: the accepting edge latches the beat, the next
// cycle compares in all cells, applies shifts/refresh and registers the result.
// One item is in work at a time. Reset clears valid bits, count and output
// valid and restores the rate limit to one second.
// A stalled result holds and stalls the input; a new item may be taken at the
// edge where the result leaves, so unstalled items follow every 2 cycles.
module closed_id_reuse_rate_limit_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cirrl_pkg::in_beat_t  in_beat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cirrl_pkg::out_beat_t out_beat,
	input  logic                 cfg_we,
	input  logic [63:0]          cfg_data
);
	localparam int N = cirrl_pkg::TableDepth;

	typedef enum logic {IDLE, APPLY} state_t;
	state_t state_q;
	cirrl_pkg::in_beat_t item_q;
	logic [63:0] rate_q;
	logic [N-1:0] valid_q;
	logic [cirrl_pkg::CntW-1:0] count_q;

	cirrl_pkg::entry_t ent [N];
	cirrl_pkg::cell_flag_t flg [N];
	cirrl_pkg::cell_cmd_t cmd [N];
	cirrl_pkg::entry_t new_entry;
	cirrl_pkg::entry_t zero_entry;

	assign new_entry = '{id: item_q.corr_id, addr_hi: item_q.addr_hi,
		addr_lo: item_q.addr_lo, closed: item_q.now_ns};
	assign zero_entry = '0;

	// pick newest hits
	logic [N-1:0] id_hit, young_hit, old_hit;
	logic [N-1:0] id_first, young_first, old_first;
	logic [N-1:0] below_del;
	logic [63:0] id_pick, young_pick, old_pick;
	logic full;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			id_hit[i] = valid_q[i] & flg[i].id_hit;
			young_hit[i] = valid_q[i] & flg[i].addr_young;
			old_hit[i] = valid_q[i] & flg[i].old;
		end
		id_first = id_hit & ~(id_hit - 1'b1);
		young_first = young_hit & ~(young_hit - 1'b1);
		old_first = old_hit & ~(old_hit - 1'b1);
		id_pick = '0; young_pick = '0; old_pick = '0;
		for (int i = 0; i < N; i++) begin
			if (young_first[i]) young_pick = ent[i].id;
			if (old_first[i]) old_pick = ent[i].id;
		end
		id_pick = item_q.corr_id;
		// slots at or after the deleted one shift up
		below_del[0] = id_first[0];
		for (int i = 1; i < N; i++) below_del[i] = below_del[i-1] | id_first[i];
		full = count_q == cirrl_pkg::CntW'(N);
	end

	// per-cell commands
	always_comb begin
		for (int i = 0; i < N; i++) begin
			cmd[i] = '0;
			if (state_q == APPLY) begin
				case (item_q.op)
					cirrl_pkg::OP_ADD: begin
						cmd[i].load_new = (i == 0) && !full;
						cmd[i].shift_in = (i != 0) && !full;
					end
					cirrl_pkg::OP_DEL: cmd[i].shift_out = below_del[i] && (i != N - 1);
					cirrl_pkg::OP_CHECK: cmd[i].refresh = young_first[i];
					default: cmd[i] = '0;
				endcase
			end
		end
	end

	// row of cells
	for (genvar g = 0; g < N; g++) begin : g_cell
		cirrl_cell u_cell (
			.clk(clk),
			.prev_entry(g == 0 ? zero_entry : ent[(g == 0) ? 0 : g - 1]),
			.next_entry(g == N - 1 ? zero_entry : ent[(g == N - 1) ? g : g + 1]),
			.new_entry(new_entry),
			.cmd(cmd[g]),
			.key_id(item_q.corr_id),
			.key_hi(item_q.addr_hi),
			.key_lo(item_q.addr_lo),
			.now_ns(item_q.now_ns),
			.rate_limit_ns(rate_q),
			.entry(ent[g]),
			.flag(flg[g])
		);
	end

	// take a new beat while idle, unless a waiting result stays stalled
	assign in_stall = (state_q != IDLE) || (out_valid && out_stall);

	// control and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			valid_q <= '0;
			count_q <= '0;
			rate_q <= cirrl_pkg::RateLimitReset;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) rate_q <= cfg_data;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				IDLE: begin
					if (in_valid && !in_stall) begin
						item_q <= in_beat;
						state_q <= APPLY;
					end
				end
				APPLY: begin
					state_q <= IDLE;
					out_valid <= 1'b1;
					out_beat.status <= cirrl_pkg::ST_NOT_FOUND;
					out_beat.result_id <= '0;
					out_beat.entry_count <= 5'(count_q);
					case (item_q.op)
						cirrl_pkg::OP_ADD: begin
							if (full) begin
								out_beat.status <= cirrl_pkg::ST_FULL;
							end else begin
								valid_q <= {valid_q[N-2:0], 1'b1};
								count_q <= count_q + 1'b1;
								out_beat.entry_count <= 5'(count_q + 1'b1);
								out_beat.status <= cirrl_pkg::ST_OK;
								out_beat.result_id <= item_q.corr_id;
							end
						end
						cirrl_pkg::OP_DEL: begin
							if (|id_hit) begin
								valid_q <= {1'b0, valid_q[N-1:1]};
								count_q <= count_q - 1'b1;
								out_beat.entry_count <= 5'(count_q - 1'b1);
								out_beat.status <= cirrl_pkg::ST_OK;
								out_beat.result_id <= id_pick;
							end
						end
						cirrl_pkg::OP_FIND: begin
							if (|id_hit) begin
								out_beat.status <= cirrl_pkg::ST_OK;
								out_beat.result_id <= id_pick;
							end
						end
						cirrl_pkg::OP_CHECK: begin
							if (|young_hit) begin
								out_beat.status <= cirrl_pkg::ST_RATE_LIMITED;
								out_beat.result_id <= young_pick;
							end else if (|old_hit) begin
								out_beat.status <= cirrl_pkg::ST_REUSABLE;
								out_beat.result_id <= old_pick;
							end
						end
						cirrl_pkg::OP_CLEAR: begin
							valid_q <= '0;
							count_q <= '0;
							out_beat.status <= cirrl_pkg::ST_OK;
							out_beat.entry_count <= '0;
						end
						default: ;
					endcase
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// checks
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == cirrl_pkg::CntW'($countones(valid_q)))
		else $error("count and valid bits disagree");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == APPLY |=> out_valid)
		else $error("result missing");
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cirrl_pkg::CntW'(N))
		else $error("count overflow");
endmodule

>>> rtl/cirrl_cell.sv
// One table slot: holds an entry, compares against the broadcast item and
// hands its entry to neighbors on shifts. Uses cirrl_pkg.
module cirrl_cell (
	input  logic               clk,
	input  cirrl_pkg::entry_t  prev_entry,
	input  cirrl_pkg::entry_t  next_entry,
	input  cirrl_pkg::entry_t  new_entry,
	input  cirrl_pkg::cell_cmd_t cmd,
	input  logic [63:0]        key_id,
	input  logic [63:0]        key_hi,
	input  logic [63:0]        key_lo,
	input  logic [63:0]        now_ns,
	input  logic [63:0]        rate_limit_ns,
	output cirrl_pkg::entry_t  entry,
	output cirrl_pkg::cell_flag_t flag
);
	cirrl_pkg::entry_t entry_q;
	logic [63:0] age;

	// compare entry against the item
	always_comb begin
		age = now_ns - entry_q.closed;
		flag.id_hit = entry_q.id == key_id;
		flag.addr_young = entry_q.addr_hi == key_hi && entry_q.addr_lo == key_lo
			&& age <= rate_limit_ns;
		flag.old = age > rate_limit_ns;
	end

	// hold, shift, load or refresh the closed time
	always_ff @(posedge clk) begin
		if (cmd.load_new) begin
			entry_q <= new_entry;
		end else if (cmd.shift_in) begin
			entry_q <= prev_entry;
		end else if (cmd.shift_out) begin
			entry_q <= next_entry;
		end else if (cmd.refresh) begin
			entry_q.closed <= now_ns;
		end
	end

	assign entry = entry_q;
endmodule

>>> bench/tb.sv
// Self-checking bench for closed_id_reuse_rate_limit_table.
// Needs cirrl_pkg and the RTL of the table; holds its own model of the table
// and checks every result beat in order.
module tb;
	localparam logic [2:0] OP_BAD_LO = 3'd5;
	localparam logic [2:0] OP_BAD_HI = 3'd7;
	localparam int ItemsPerPhase = 325;
	localparam int HoldCycles = 300;

	typedef struct {
		cirrl_pkg::in_beat_t  beat;
		bit                   typed;
		cirrl_pkg::out_beat_t want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	cirrl_pkg::in_beat_t  in_beat = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	cirrl_pkg::out_beat_t out_beat;
	logic                 cfg_we = 1'b0;
	logic [63:0]          cfg_data = '0;

	// model state of the table
	cirrl_pkg::entry_t tbl [cirrl_pkg::TableDepth];
	int                tbl_count = 0;
	logic [63:0]       limit_ns = cirrl_pkg::RateLimitReset;
	logic [63:0]       clock_ns = 64'd5000;

	cirrl_pkg::out_beat_t pending_results[$];
	dir_row_t    dir_rows[$];
	int          send_pct = 0;
	int          recv_pct = 0;
	int          mismatches = 0;
	bit          hold_go = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;

	closed_id_reuse_rate_limit_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat (out_beat),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// apply one operation to the model table and return its result
	function automatic cirrl_pkg::out_beat_t predict_table(cirrl_pkg::in_beat_t b);
		cirrl_pkg::out_beat_t r;
		int hit;
		int i;
		r.status = cirrl_pkg::ST_NOT_FOUND;
		r.result_id = '0;
		hit = -1;
		case (b.op)
			cirrl_pkg::OP_ADD: begin
				if (tbl_count >= cirrl_pkg::TableDepth) begin
					r.status = cirrl_pkg::ST_FULL;
				end else begin
					for (i = tbl_count; i > 0; i--) tbl[i] = tbl[i-1];
					tbl[0] = '{b.corr_id, b.addr_hi, b.addr_lo, b.now_ns};
					tbl_count++;
					r.status = cirrl_pkg::ST_OK;
					r.result_id = b.corr_id;
				end
			end
			cirrl_pkg::OP_DEL, cirrl_pkg::OP_FIND: begin
				for (i = 0; i < tbl_count; i++)
					if (hit < 0 && tbl[i].id == b.corr_id) hit = i;
				if (hit >= 0) begin
					r.status = cirrl_pkg::ST_OK;
					r.result_id = b.corr_id;
					if (b.op == cirrl_pkg::OP_DEL) begin
						for (i = hit; i + 1 < tbl_count; i++) tbl[i] = tbl[i+1];
						tbl_count--;
					end
				end
			end
			cirrl_pkg::OP_CHECK: begin
				// newest young entry of this host first, else newest old entry of any host
				for (i = 0; i < tbl_count; i++)
					if (hit < 0 && tbl[i].addr_hi == b.addr_hi && tbl[i].addr_lo == b.addr_lo
							&& b.now_ns - tbl[i].closed <= limit_ns) hit = i;
				if (hit >= 0) begin
					r.status = cirrl_pkg::ST_RATE_LIMITED;
					r.result_id = tbl[hit].id;
					tbl[hit].closed = b.now_ns;
				end else begin
					for (i = 0; i < tbl_count; i++)
						if (hit < 0 && b.now_ns - tbl[i].closed > limit_ns) hit = i;
					if (hit >= 0) begin
						r.status = cirrl_pkg::ST_REUSABLE;
						r.result_id = tbl[hit].id;
					end
				end
			end
			cirrl_pkg::OP_CLEAR: begin
				tbl_count = 0;
				r.status = cirrl_pkg::ST_OK;
			end
			default: ;
		endcase
		r.entry_count = tbl_count[4:0];
		return r;
	endfunction

	// compare one result beat with the oldest expectation
	task automatic check_result(cirrl_pkg::out_beat_t got);
		cirrl_pkg::out_beat_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result beat %h", got);
		end else begin
			want = pending_results.pop_front();
			if (got.status !== want.status || got.result_id !== want.result_id
					|| got.entry_count !== want.entry_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: status %0d/%0d id %h/%h count %0d/%0d (exp/got)",
						want.status, got.status, want.result_id, got.result_id,
						want.entry_count, got.entry_count);
			end
		end
	endtask

	// receive side: check accepted beats, stall at random or for one long hold
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) check_result(out_beat);
		if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HoldCycles;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (recv_pct != 0) && ($urandom_range(0, 99) < recv_pct);
		end
	end

	// offer one beat, hold it until taken, then predict its result
	task automatic send_beat(cirrl_pkg::in_beat_t b, bit typed, cirrl_pkg::out_beat_t want);
		cirrl_pkg::out_beat_t r;
		while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= b;
		do @(posedge clk); while (in_stall);
		r = predict_table(b);
		pending_results.push_back(typed ? want : r);
	endtask

	// drain, then write the rate limit while the table is idle
	task automatic set_limit(logic [63:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_ns = v;
	endtask

	function automatic logic [127:0] pick_addr();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210;
			3: return 128'hffff_0000_0000_0001_8000_0000_0000_0000;
			default: return {$urandom, $urandom, $urandom, $urandom};
		endcase
	endfunction

	// random operation over a small pool of IDs and hosts, time mostly advancing
	function automatic cirrl_pkg::in_beat_t rand_beat();
		cirrl_pkg::in_beat_t b;
		int pick;
		logic [127:0] a;
		pick = $urandom_range(0, 99);
		if (pick < 35) b.op = cirrl_pkg::OP_ADD;
		else if (pick < 50) b.op = cirrl_pkg::OP_DEL;
		else if (pick < 65) b.op = cirrl_pkg::OP_FIND;
		else if (pick < 93) b.op = cirrl_pkg::OP_CHECK;
		else if (pick < 96) b.op = cirrl_pkg::OP_CLEAR;
		else b.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
		b.corr_id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
			: 64'($urandom_range(0, 15));
		a = pick_addr();
		b.addr_hi = a[127:64];
		b.addr_lo = a[63:0];
		if (limit_ns > 64'd1 << 40) clock_ns += $urandom_range(0, 3);
		else clock_ns += (limit_ns / 4) * $urandom_range(0, 3) + $urandom_range(0, 2);
		b.now_ns = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : clock_ns;
		return b;
	endfunction

	function automatic dir_row_t mk_row(logic [2:0] op, logic [63:0] id, logic [127:0] a,
			logic [63:0] t, bit typed, logic [2:0] st, logic [63:0] rid, logic [4:0] cnt);
		dir_row_t row;
		row.beat = '{op, id, a[127:64], a[63:0], t};
		row.typed = typed;
		row.want = '{st, rid, cnt};
		return row;
	endfunction

	initial begin
		logic [63:0] limits [4];
		int p;
		int n;
		limits = '{64'd0, '1, 64'd1000, 64'd1000000000};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: empty table, extremes, unknown ops, fill to full, clear
		dir_rows.push_back(mk_row(cirrl_pkg::OP_FIND, 64'd5, '0, '0, 1'b1,
			cirrl_pkg::ST_NOT_FOUND, '0, 5'd0));
		dir_rows.push_back(mk_row(cirrl_pkg::OP_DEL, 64'd5, '0, '0, 1'b1,
			cirrl_pkg::ST_NOT_FOUND, '0, 5'd0));
		dir_rows.push_back(mk_row(cirrl_pkg::OP_CHECK, '1, '1, '0, 1'b1,
			cirrl_pkg::ST_NOT_FOUND, '0, 5'd0));
		dir_rows.push_back(mk_row(OP_BAD_LO, '1, '1, '1, 1'b1,
			cirrl_pkg::ST_NOT_FOUND, '0, 5'd0));
		dir_rows.push_back(mk_row(OP_BAD_HI, '0, '0, '0, 1'b1,
			cirrl_pkg::ST_NOT_FOUND, '0, 5'd0));
		dir_rows.push_back(mk_row(cirrl_pkg::OP_ADD, '1, '1, '1, 1'b1,
			cirrl_pkg::ST_OK, '1, 5'd1));
		dir_rows.push_back(mk_row(cirrl_pkg::OP_ADD, '0, '0, '0, 1'b1,
			cirrl_pkg::ST_OK, '0, 5'd2));
		// closed time in the future wraps to a small age
		dir_rows.push_back(mk_row(cirrl_pkg::OP_CHECK, '0, '1, '0, 1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(cirrl_pkg::OP_CHECK, '0, '0, 64'd2000000000, 1'b0,
			'0, '0, '0));
		dir_rows.push_back(mk_row(cirrl_pkg::OP_FIND, '0, '0, '0, 1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(cirrl_pkg::OP_DEL, '1, '0, '0, 1'b0, '0, '0, '0));
		for (n = 0; n < cirrl_pkg::TableDepth - 1; n++)
			dir_rows.push_back(mk_row(cirrl_pkg::OP_ADD, 64'(n + 100), 128'(n), 64'(n),
				1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(cirrl_pkg::OP_ADD, 64'd7, '0, '0, 1'b1,
			cirrl_pkg::ST_FULL, '0, 5'(cirrl_pkg::TableDepth)));
		dir_rows.push_back(mk_row(cirrl_pkg::OP_CLEAR, '0, '0, '0, 1'b1,
			cirrl_pkg::ST_OK, '0, 5'd0));

		set_limit(cirrl_pkg::RateLimitReset);
		foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

		// random phases over several rate limits and idle patterns
		for (p = 0; p < 4; p++) begin
			set_limit(limits[p]);
			send_pct = (p == 0) ? 36 : (p == 1) ? 45 : 0;
			recv_pct = (p == 0) ? 45 : (p == 1) ? 36 : 0;
			if (p == 3) hold_go = 1'b1;
			for (n = 0; n < ItemsPerPhase; n++) send_beat(rand_beat(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/cirrl_pkg.sv
rtl/cirrl_cell.sv
rtl/closed_id_reuse_rate_limit_table.sv
bench/tb.sv
